### hw/rtl/dosw_pkg.sv
// ---------------------------------------------------------------------------
// dosw_pkg: shared definitions for the discrete-ordinates cell sweep
// Widths of the wide datapath and the status group of the shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

package dosw_pkg;

  // Width of the cell numerator and denominator.
  localparam int WIDE_W = 100;
  // Quotient bits produced by one division pass.
  localparam int QUOT_W = 33;

  // Status reported by the divider to the sequencer.
  typedef struct packed {
    logic              done;
    logic              over;
    logic [QUOT_W-1:0] quot;
  } div_status_t;

endpackage

`default_nettype wire

### hw/rtl/discrete_ordinates_cell_sweep.sv
// ---------------------------------------------------------------------------
// discrete_ordinates_cell_sweep: weighted-diamond sweep of a 1D slab
// Computes one cell intensity per input request, chains the exit face into
// the next cell, and emits the exit boundary intensity on the last cell.
//
//   channel  direction  carries
//   s_axis   in         one cell: cosine, weight, source, extinction, wall
//   m_axis   out        cell intensity, then exit face on the last cell
//   cfg      in         face_weight (index 0), cell_width (index 1)
//
// Each cell makes eleven passes through the shared 32x32 multiplier, each
// through S_MUL_A and S_MUL_B, and one pass through the shared divider
// (start, 33 quotient bits, done) for the cell, plus a second for the exit
// face unless face_weight is zero. A request with zero direction cosine is
// accepted and gives nothing, and the block stays idle for the next request.
// Reset is synchronous; it restores the register defaults and clears the
// entry face. s_axis is not ready while a cell is in work; a cell waits in its
// final state until the two-entry output queue has room for its results.
// ---------------------------------------------------------------------------
`default_nettype none

module discrete_ordinates_cell_sweep (
  input  wire logic         clk,
  input  wire logic         rst,
  // s_axis_tdata, low bit up: direction_cosine[15:0], solid_angle_weight[35:16],
  // source_term[67:36], extinction[98:68], boundary_intensity[129:99], zero pad
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,
  // s_axis_tuser: first_cell[0]
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // m_axis_tdata: intensity[31:0]
  output logic      [31:0]  m_axis_tdata,
  // m_axis_tuser, low bit up: value_kind[0], saturated[1]
  output logic      [1:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  import dosw_pkg::*;

  localparam logic [0:0] REG_FACE_WEIGHT = 1'd0;
  localparam logic [0:0] REG_CELL_WIDTH  = 1'd1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_A = 4'd1;
  localparam logic [3:0] S_MUL_B = 4'd2;
  localparam logic [3:0] S_NUM   = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_WAIT1 = 4'd5;
  localparam logic [3:0] S_CELL  = 4'd6;
  localparam logic [3:0] S_FSUM  = 4'd7;
  localparam logic [3:0] S_WAIT2 = 4'd8;
  localparam logic [3:0] S_FACE  = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;

  // Multiplier passes.
  localparam logic [3:0] OP_DV    = 4'd0;
  localparam logic [3:0] OP_T_LO  = 4'd1;
  localparam logic [3:0] OP_T_HI  = 4'd2;
  localparam logic [3:0] OP_S0    = 4'd3;
  localparam logic [3:0] OP_S1    = 4'd4;
  localparam logic [3:0] OP_S2    = 4'd5;
  localparam logic [3:0] OP_EM    = 4'd6;
  localparam logic [3:0] OP_K0    = 4'd7;
  localparam logic [3:0] OP_K1    = 4'd8;
  localparam logic [3:0] OP_K2    = 4'd9;
  localparam logic [3:0] OP_DM    = 4'd10;

  localparam logic [16:0] D_ONE   = 17'h1_0000;
  localparam logic [32:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [32:0] LIM_NEG = 33'h0_8000_0000;

  typedef struct packed {
    logic [31:0] intensity;
    logic        value_kind;
    logic        saturated;
    logic        last_of_run;
  } res_t;

  // Saturate a signed magnitude quotient; returns {clipped, value}.
  function automatic logic [32:0] sat_quot(logic [32:0] q, logic big, logic neg);
    logic clip;
    logic [32:0] r;
    clip = big || (neg ? (q > LIM_NEG) : (q > LIM_POS));
    if (clip) begin
      r = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, neg ? (~q[31:0] + 32'd1) : q[31:0]};
    end
    return r;
  endfunction

  // Configuration and persistent state.
  logic [16:0] face_weight;
  logic [30:0] cell_width;
  logic [31:0] entry_face;

  // Sequencer.
  logic [3:0] state;
  logic [3:0] op;

  // Latched item fields.
  logic [15:0] mmag;
  logic [19:0] wgt;
  logic [31:0] smag;
  logic        sneg;
  logic [30:0] ext;
  logic [31:0] eabs;
  logic        eneg;
  logic        last;

  // Intermediate results.
  logic [47:0]       dv;
  logic [67:0]       t;
  logic [WIDE_W-1:0] acc;
  logic [46:0]       em;
  logic [47:0]       dm;
  logic [WIDE_W-1:0] num;
  logic              nneg;
  logic [31:0]       cell_int;
  logic              csat;
  logic              fneg;
  logic [31:0]       face;
  logic              fsat;

  // Output queue.
  res_t       q [2];
  res_t       q0_next;
  res_t       q1_next;
  logic [1:0] qcnt;

  // Shared units.
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic              div_start;
  logic [WIDE_W-1:0] div_hi;
  logic [QUOT_W-1:0] div_lo;
  logic [WIDE_W-1:0] div_den;
  div_status_t       div_st;

  // Input field views.
  logic signed [15:0] in_mu;
  logic signed [31:0] in_src;
  logic [31:0]        in_e;

  assign in_mu  = s_axis_tdata[15:0];
  assign in_src = s_axis_tdata[67:36];
  assign in_e   = s_axis_tuser[0] ? {1'b0, s_axis_tdata[129:99]} : entry_face;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // Source and extinction sums against the entering intensity term.
  logic [WIDE_W-1:0] emag;
  assign emag = {19'd0, em, 34'd0};

  // Face weight offset from one, with its sign against the entry sign.
  logic [16:0] dmag;
  logic        dneg;
  assign dmag = (face_weight >= D_ONE) ? 17'(face_weight - D_ONE) : 17'(D_ONE - face_weight);
  assign dneg = (face_weight < D_ONE) ^ eneg;

  // Face dividend: cell * 2^16 + (d - 1) * e, signed.
  logic [49:0] fn;
  logic [49:0] fn_abs;
  assign fn     = {{2{cell_int[31]}}, cell_int, 16'd0}
                + (dneg ? (50'd0 - {2'd0, dm}) : {2'd0, dm});
  assign fn_abs = fn[49] ? (50'd0 - fn) : fn;

  // Multiplier operand selection.
  always_comb begin
    case (op)
      OP_DV:   begin mul_a = {15'd0, face_weight}; mul_b = {1'b0, cell_width}; end
      OP_T_LO: begin mul_a = dv[31:0];             mul_b = {12'd0, wgt};       end
      OP_T_HI: begin mul_a = {16'd0, dv[47:32]};   mul_b = {12'd0, wgt};       end
      OP_S0:   begin mul_a = t[31:0];              mul_b = smag;               end
      OP_S1:   begin mul_a = t[63:32];             mul_b = smag;               end
      OP_S2:   begin mul_a = {28'd0, t[67:64]};    mul_b = smag;               end
      OP_EM:   begin mul_a = eabs;                 mul_b = {16'd0, mmag};      end
      OP_K0:   begin mul_a = t[31:0];              mul_b = {1'b0, ext};        end
      OP_K1:   begin mul_a = t[63:32];             mul_b = {1'b0, ext};        end
      OP_K2:   begin mul_a = {28'd0, t[67:64]};    mul_b = {1'b0, ext};        end
      OP_DM:   begin mul_a = {15'd0, dmag};        mul_b = eabs;               end
      default: begin mul_a = '0;                   mul_b = '0;                 end
    endcase
  end

  // Divider operands: cell division, or face division by face_weight.
  always_comb begin
    div_start = (state == S_DIV1) || (state == S_FSUM && face_weight != '0);
    if (state == S_DIV1) begin
      div_hi  = {17'd0, num[WIDE_W-1:17]};
      div_lo  = {num[16:0], 16'd0};
      div_den = acc;
    end else begin
      div_hi  = {84'd0, fn_abs[48:33]};
      div_lo  = fn_abs[32:0];
      div_den = {83'd0, face_weight};
    end
  end

  dosw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dosw_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .status (div_st)
  );

  // Queue handshake and push sizing.
  logic       pop;
  logic [1:0] qcnt_pop;
  logic       push_ok;
  res_t       ra;
  res_t       rb;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign qcnt_pop = qcnt - {1'b0, pop};
  assign push_ok  = (state == S_PUSH) && (last ? (qcnt_pop == 2'd0) : (qcnt_pop < 2'd2));
  assign ra       = '{intensity: cell_int, value_kind: 1'b0, saturated: csat,
                      last_of_run: !last};
  assign rb       = '{intensity: face, value_kind: 1'b1, saturated: fsat, last_of_run: 1'b1};

  assign m_axis_tvalid = (qcnt != 2'd0);
  assign m_axis_tdata  = q[0].intensity;
  assign m_axis_tuser  = {q[0].saturated, q[0].value_kind};
  assign m_axis_tlast  = q[0].last_of_run;

  // Sequencer, configuration and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_DV;
      face_weight <= 17'd32768;
      cell_width  <= 31'd65536;
      entry_face  <= '0;
      qcnt        <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FACE_WEIGHT: face_weight <= cfg_data[16:0];
          REG_CELL_WIDTH:  cell_width  <= cfg_data;
        endcase
      end

      qcnt <= push_ok ? (qcnt_pop + (last ? 2'd2 : 2'd1)) : qcnt_pop;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && in_mu != '0) begin
            state <= S_MUL_A;
            op    <= OP_DV;
          end
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: begin
          case (op)
            OP_EM:   state <= S_NUM;
            OP_K2:   state <= S_DIV1;
            OP_DM:   state <= S_FSUM;
            default: begin
              state <= S_MUL_A;
              op    <= op + 4'd1;
            end
          endcase
        end
        S_NUM: begin
          state <= S_MUL_A;
          op    <= OP_K0;
        end
        S_DIV1:  state <= S_WAIT1;
        S_WAIT1: if (div_st.done) state <= S_CELL;
        S_CELL: begin
          state <= S_MUL_A;
          op    <= OP_DM;
        end
        S_FSUM:  state <= (face_weight == '0) ? S_PUSH : S_WAIT2;
        S_WAIT2: if (div_st.done) state <= S_FACE;
        S_FACE:  state <= S_PUSH;
        S_PUSH: begin
          if (push_ok) begin
            state      <= S_IDLE;
            entry_face <= face;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item capture and datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      mmag <= in_mu[15] ? 16'(-in_mu) : 16'(in_mu);
      wgt  <= s_axis_tdata[35:16];
      sneg <= in_src[31];
      smag <= in_src[31] ? 32'(-in_src) : 32'(in_src);
      ext  <= s_axis_tdata[98:68];
      eneg <= in_e[31];
      eabs <= in_e[31] ? 32'(-in_e) : in_e;
      last <= s_axis_tlast;
    end

    // Load or accumulate each registered product into its target.
    if (state == S_MUL_B) begin
      case (op)
        OP_DV:   dv  <= mul_p[47:0];
        OP_T_LO: t   <= {4'd0, mul_p};
        OP_T_HI: t   <= t + {mul_p[35:0], 32'd0};
        OP_S0:   acc <= {36'd0, mul_p};
        OP_S1:   acc <= acc + {4'd0, mul_p, 32'd0};
        OP_S2:   acc <= acc + {mul_p[35:0], 64'd0};
        OP_EM:   em  <= mul_p[46:0];
        OP_K0:   acc <= {34'd0, mmag, 50'd0} + {36'd0, mul_p};
        OP_K1:   acc <= acc + {4'd0, mul_p, 32'd0};
        OP_K2:   acc <= acc + {mul_p[35:0], 64'd0};
        OP_DM:   dm  <= mul_p[47:0];
        default: dm  <= dm;
      endcase
    end

    // Signed numerator from the source and entering terms.
    if (state == S_NUM) begin
      if (eneg == sneg) begin
        num  <= emag + acc;
        nneg <= eneg;
      end else if (emag >= acc) begin
        num  <= emag - acc;
        nneg <= eneg;
      end else begin
        num  <= acc - emag;
        nneg <= sneg;
      end
    end

    if (state == S_CELL) begin
      {csat, cell_int} <= sat_quot(div_st.quot, div_st.over, nneg);
    end

    // Zero face weight passes the cell straight through as the face.
    if (state == S_FSUM) begin
      fneg <= fn[49];
      if (face_weight == '0) begin
        face <= cell_int;
        fsat <= 1'b0;
      end
    end

    if (state == S_FACE) begin
      {fsat, face} <= sat_quot(div_st.quot, div_st.over, fneg);
    end
  end

  // Next queue contents: shift on a pop, then place new results behind.
  always_comb begin
    q0_next = pop ? q[1] : q[0];
    q1_next = q[1];
    if (push_ok) begin
      if (last) begin
        q0_next = ra;
        q1_next = rb;
      end else if (qcnt_pop[0]) begin
        q1_next = ra;
      end else begin
        q0_next = ra;
      end
    end
  end

  // Output queue entries.
  always_ff @(posedge clk) begin
    q[0] <= q0_next;
    q[1] <= q1_next;
  end

endmodule

`default_nettype wire

### hw/rtl/dosw_mul.sv
// ---------------------------------------------------------------------------
// dosw_mul: shared 32 x 32 unsigned multiplier
// Operands are taken each cycle; the product is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module dosw_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  // One registered partial product per cycle.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

### hw/rtl/dosw_div.sv
// ---------------------------------------------------------------------------
// dosw_div: iterative restoring divider
// Forms a 33-bit quotient of {num_hi, num_lo} / den, one bit per cycle, and
// flags when the true quotient does not fit in 33 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module dosw_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dosw_pkg::WIDE_W-1:0]   num_hi,
  input  wire logic [dosw_pkg::QUOT_W-1:0]   num_lo,
  input  wire logic [dosw_pkg::WIDE_W-1:0]   den,
  output dosw_pkg::div_status_t              status
);

  import dosw_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] dvs;
  logic [QUOT_W-1:0] lo;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic              over;
  logic              done;
  logic [WIDE_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and compare against the divisor.
  assign trial = {rem, lo[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(QUOT_W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Datapath: remainder, dividend shift register and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num_hi;
      lo   <= num_lo;
      dvs  <= den;
      over <= num_hi >= den;
      quot <= '0;
    end else if (cnt != '0) begin
      lo   <= {lo[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], fits};
      if (fits) begin
        rem <= WIDE_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[WIDE_W-1:0];
      end
    end
  end

  assign status.done = done;
  assign status.over = over;
  assign status.quot = quot;

endmodule

`default_nettype wire

### hw/rtl/dosw_check.sv
// ---------------------------------------------------------------------------
// dosw_check: port-level checks for the cell sweep
// Watches the input and output stream ports and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dosw_check (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [135:0] s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // An accepted cell with a nonzero direction cosine makes the block busy, so input ready drops.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[15:0] != 16'd0) |=> !s_axis_tready)
    else $error("input ready right after an accepted request");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The exit face is always the final result of its cell.
  a_face_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("exit face without last marker");

  // Reset empties the output queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind discrete_ordinates_cell_sweep dosw_check u_dosw_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
